@@ sv/gmlr_pkg.sv @@
// Shared types, constants and table-building functions for the grid log-ratio estimator.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package gmlr_pkg;

  localparam int unsigned GRID_POINTS_DEF = 256;

  // Configuration register file
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRIOR_VAR  = 2'd0,
    CFG_NOISE_VAR  = 2'd1,
    CFG_PRIOR_MEAN = 2'd2
  } cfg_reg_t;

  localparam logic [31:0] PRIOR_VAR_RST  = 32'd32768;
  localparam logic [31:0] NOISE_VAR_RST  = 32'd32768;
  localparam logic [15:0] PRIOR_MEAN_RST = 16'd0;

  // Datapath widths
  localparam int COST_W = 48;
  localparam int E_W    = 38;
  localparam int G_W    = 38;
  localparam int H_W    = 60;
  localparam int T1_W   = 40;
  localparam int R_OUT_W = 15;
  localparam int IDX_OUT_W = 8;

  localparam longint unsigned Q31_ONE = 64'h0000_0000_8000_0000;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } ctl_t;

  typedef struct packed {
    logic signed [15:0] r;
    logic [31:0]        z;
    logic [31:0]        inv;
    logic [31:0]        hl;
  } grid_entry_t;

  // Restoring long division, used only while the tables are elaborated.
  function automatic longint unsigned udiv(input longint unsigned num,
                                           input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = 64'd0;
    rem = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      quo = {quo[62:0], 1'b0};
      if (rem >= den) begin
        rem    = rem - den;
        quo[0] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic longint unsigned q31_mul(input longint unsigned a,
                                              input longint unsigned b);
    return (a * b + (64'd1 << 30)) >> 31;
  endfunction

  // exp(-a/4096) in Q1.31
  function automatic longint unsigned exp_neg_q31(input longint unsigned a);
    longint unsigned t;
    longint unsigned sum;
    longint unsigned term;
    t    = a << 15;
    sum  = Q31_ONE;
    term = Q31_ONE;
    for (int n = 1; n <= 12; n++) begin
      term = q31_mul(term, t);
      term = udiv(term + longint'(n >> 1), longint'(n));
      if ((n & 1) != 0) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    for (int sq = 0; sq < 4; sq++) begin
      sum = q31_mul(sum, sum);
    end
    return sum;
  endfunction

  // 0.5*ln(1 + y/2^31) in Q31
  function automatic longint unsigned half_ln1p_q31(input longint unsigned y);
    longint unsigned den;
    longint unsigned w;
    longint unsigned w2;
    longint unsigned term;
    longint unsigned sum;
    den  = (64'd1 << 32) + y;
    w    = udiv((y << 31) + (den >> 1), den);
    w2   = q31_mul(w, w);
    term = w;
    sum  = 64'd0;
    for (int k = 1; k <= 21; k += 2) begin
      sum  = sum + udiv(term + longint'(k >> 1), longint'(k));
      term = q31_mul(term, w2);
    end
    return sum;
  endfunction

  function automatic grid_entry_t grid_entry(input int i, input int n);
    int              k;
    longint unsigned ak;
    longint unsigned mag;
    longint unsigned q;
    longint unsigned q2;
    longint unsigned s;
    longint unsigned hl;
    longint unsigned z;
    longint unsigned inv;
    grid_entry_t     e;
    k   = i - (n >> 1);
    ak  = (k < 0) ? longint'(-k) : longint'(k);
    mag = udiv(ak * 64'd32768 + longint'(n >> 1), longint'(n));
    q   = exp_neg_q31(mag);
    q2  = q31_mul(q, q);
    s   = Q31_ONE + q2;
    hl  = (half_ln1p_q31(q2) + (64'd1 << 14)) >> 15;
    if (k >= 0) begin
      z   = udiv((64'd1 << 47) + (q >> 1), q);
      inv = udiv((q2 << 31) + (s >> 1), s);
      hl  = hl + (mag << 4);
      e.r = mag[15:0];
    end else begin
      z   = (q + (64'd1 << 14)) >> 15;
      inv = udiv((64'd1 << 62) + (s >> 1), s);
      e.r = -mag[15:0];
    end
    e.z   = z[31:0];
    e.inv = inv[31:0];
    e.hl  = hl[31:0];
    return e;
  endfunction

endpackage

`default_nettype wire

@@ sv/gmlr_grid_rom.sv @@
// Read-only grid table: r, exp(r), 1/(1+z^2) and 0.5*ln(1+z^2) per grid point.
// Depends on gmlr_pkg for the entry type and the functions that build the contents.
`default_nettype none

module gmlr_grid_rom #(
  parameter int GRID_POINTS = gmlr_pkg::GRID_POINTS_DEF,
  parameter int IDX_W       = $clog2(GRID_POINTS)
) (
  input  wire logic [IDX_W-1:0] idx,
  output gmlr_pkg::grid_entry_t entry
);

  gmlr_pkg::grid_entry_t rom [GRID_POINTS];

  for (genvar i = 0; i < GRID_POINTS; i++) begin : g_rom
    localparam gmlr_pkg::grid_entry_t ENTRY = gmlr_pkg::grid_entry(i, GRID_POINTS);
    assign rom[i] = ENTRY;
  end

  assign entry = rom[idx];

endmodule

`default_nettype wire

@@ sv/gmlr_cost_pipe.sv @@
// Nine-stage cost pipeline: one grid point enters per cycle while adv is high; its saturated cost leaves.
// Depends on gmlr_pkg and gmlr_grid_rom.
`default_nettype none

module gmlr_cost_pipe #(
  parameter int GRID_POINTS = gmlr_pkg::GRID_POINTS_DEF,
  parameter int IDX_W       = $clog2(GRID_POINTS)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          adv,
  input  wire gmlr_pkg::ctl_t                in_ctl,
  input  wire logic [IDX_W-1:0]              in_idx,
  input  wire logic signed [31:0]            in_u,
  input  wire logic signed [31:0]            in_v,
  input  wire logic [31:0]                   prior_var,
  input  wire logic [31:0]                   noise_var,
  input  wire logic signed [15:0]            prior_mean,
  output gmlr_pkg::ctl_t                     out_ctl,
  output logic [IDX_W-1:0]                   out_idx,
  output logic [gmlr_pkg::R_OUT_W-1:0]       out_r,
  output logic [gmlr_pkg::COST_W-1:0]        out_cost
);

  localparam int NSTG   = 9;
  localparam int E_W    = gmlr_pkg::E_W;
  localparam int G_W    = gmlr_pkg::G_W;
  localparam int H_W    = gmlr_pkg::H_W;
  localparam int T1_W   = gmlr_pkg::T1_W;
  localparam int COST_W = gmlr_pkg::COST_W;
  localparam int R_W    = gmlr_pkg::R_OUT_W;

  gmlr_pkg::ctl_t        ctl_r [1:NSTG];
  logic [IDX_W-1:0]      idx_r [1:NSTG];
  logic [R_W-1:0]        rv_r  [1:NSTG];
  logic [31:0]           hl_r  [1:8];

  gmlr_pkg::grid_entry_t ent;

  gmlr_grid_rom #(
    .GRID_POINTS(GRID_POINTS),
    .IDX_W      (IDX_W)
  ) u_rom (
    .idx  (in_idx),
    .entry(ent)
  );

  // Stage 1: table read, distance from the prior mean, v*z
  logic signed [16:0] d_nxt;
  logic [15:0]        ad_nxt;
  logic signed [64:0] vz_full;
  logic signed [31:0] u1_r;
  logic [55:0]        vz1_r;
  logic [15:0]        ad1_r;
  logic [31:0]        inv1_r;

  assign d_nxt   = {ent.r[15], ent.r} - {prior_mean[15], prior_mean};
  assign ad_nxt  = d_nxt[16] ? 16'(-d_nxt) : d_nxt[15:0];
  assign vz_full = $signed(in_v) * $signed({1'b0, ent.z});

  // Stage 2: rounded magnitude of the residual, square of the distance
  logic [55:0] u_ext;
  logic [55:0] diff_nxt;
  logic [55:0] adiff;
  logic [55:0] esum;
  logic [E_W-1:0] e2_r;
  logic [31:0]    ad2_r;
  logic [31:0]    inv2_r;

  assign u_ext    = {{8{u1_r[31]}}, u1_r, 16'h0000};
  assign diff_nxt = u_ext - vz1_r;
  assign adiff    = diff_nxt[55] ? (56'd0 - diff_nxt) : diff_nxt;
  assign esum     = adiff + 56'd32768;

  // Stage 3: partial products of e*inv and the prior term product
  logic [E_W-1:0] e3_r;
  logic [50:0]    pg_lo3_r;
  logic [50:0]    pg_hi3_r;
  logic [63:0]    t1p3_r;

  // Stage 4: g and the prior term
  logic [70:0]     gsum;
  logic [64:0]     t1sum;
  logic [E_W-1:0]  e4_r;
  logic [G_W-1:0]  g4_r;
  logic [T1_W-1:0] t1_r [4:8];

  assign gsum  = (71'(pg_hi3_r) << 19) + 71'(pg_lo3_r) + (71'd1 << 30);
  assign t1sum = 65'(t1p3_r) + (65'd1 << 23);

  // Stage 5: partial products of e*g
  logic [56:0] ph_lo5_r;
  logic [56:0] ph_hi5_r;

  // Stage 6: h
  logic [76:0]    hsum;
  logic [H_W-1:0] h6_r;

  assign hsum = (77'(ph_hi5_r) << 19) + 77'(ph_lo5_r) + (77'd1 << 15);

  // Stage 7: partial products of h*noise
  logic [61:0] pn_lo7_r;
  logic [61:0] pn_hi7_r;

  // Stage 8: noise term, rounded and saturated
  logic [92:0]       nsum;
  logic [COST_W-1:0] t2_nxt;
  logic [COST_W-1:0] t28_r;

  assign nsum   = (93'(pn_hi7_r) << 30) + 93'(pn_lo7_r) + (93'd1 << 15);
  assign t2_nxt = (|nsum[92:64]) ? {COST_W{1'b1}} : nsum[63:16];

  // Stage 9: saturating sum of the three terms
  logic [COST_W:0]   s1;
  logic [COST_W-1:0] s1_sat;
  logic [COST_W:0]   s2;
  logic [COST_W-1:0] cost9_r;

  assign s1     = (COST_W+1)'(t1_r[8]) + (COST_W+1)'(t28_r);
  assign s1_sat = s1[COST_W] ? {COST_W{1'b1}} : s1[COST_W-1:0];
  assign s2     = (COST_W+1)'(s1_sat) + (COST_W+1)'(hl_r[8]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 1; s <= NSTG; s++) begin
        ctl_r[s] <= '0;
      end
    end else if (adv) begin
      ctl_r[1] <= in_ctl;
      for (int s = 2; s <= NSTG; s++) begin
        ctl_r[s] <= ctl_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idx_r[1] <= in_idx;
      rv_r[1]  <= ent.r[R_W-1:0];
      hl_r[1]  <= ent.hl;
      for (int s = 2; s <= NSTG; s++) begin
        idx_r[s] <= idx_r[s-1];
        rv_r[s]  <= rv_r[s-1];
      end
      for (int s = 2; s <= 8; s++) begin
        hl_r[s] <= hl_r[s-1];
      end

      u1_r   <= in_u;
      vz1_r  <= vz_full[55:0];
      ad1_r  <= ad_nxt;
      inv1_r <= ent.inv;

      e2_r   <= esum[16+E_W-1:16];
      ad2_r  <= ad1_r * ad1_r;
      inv2_r <= inv1_r;

      e3_r     <= e2_r;
      pg_lo3_r <= e2_r[18:0] * inv2_r;
      pg_hi3_r <= e2_r[E_W-1:19] * inv2_r;
      t1p3_r   <= ad2_r * prior_var;

      e4_r    <= e3_r;
      g4_r    <= gsum[31+G_W-1:31];
      t1_r[4] <= t1sum[24+T1_W-1:24];

      ph_lo5_r <= e4_r * g4_r[18:0];
      ph_hi5_r <= e4_r * g4_r[G_W-1:19];
      for (int s = 5; s <= 8; s++) begin
        t1_r[s] <= t1_r[s-1];
      end

      h6_r <= hsum[16+H_W-1:16];

      pn_lo7_r <= h6_r[29:0] * noise_var;
      pn_hi7_r <= h6_r[H_W-1:30] * noise_var;

      t28_r <= t2_nxt;

      cost9_r <= s2[COST_W] ? {COST_W{1'b1}} : s2[COST_W-1:0];
    end
  end

  assign out_ctl  = ctl_r[NSTG];
  assign out_idx  = idx_r[NSTG];
  assign out_r    = rv_r[NSTG];
  assign out_cost = cost9_r;

endmodule

`default_nettype wire

@@ sv/gmlr_min_select.sv @@
// Running minimum over the costs of one request and the result register.
// Depends on gmlr_pkg for the control type and widths.
`default_nettype none

module gmlr_min_select #(
  parameter int GRID_POINTS = gmlr_pkg::GRID_POINTS_DEF,
  parameter int IDX_W       = $clog2(GRID_POINTS)
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire gmlr_pkg::ctl_t                     pt_ctl,
  input  wire logic [IDX_W-1:0]                   pt_idx,
  input  wire logic [gmlr_pkg::R_OUT_W-1:0]       pt_r,
  input  wire logic [gmlr_pkg::COST_W-1:0]        pt_cost,
  input  wire logic                               out_ready,
  output logic                                    stall,
  output logic                                    out_valid,
  output logic [gmlr_pkg::R_OUT_W-1:0]            out_log_ratio,
  output logic [gmlr_pkg::IDX_OUT_W-1:0]          out_best_index
);

  localparam int OW = gmlr_pkg::IDX_OUT_W;

  logic [gmlr_pkg::COST_W-1:0]  best_cost_r;
  logic [IDX_W-1:0]             best_idx_r;
  logic [gmlr_pkg::R_OUT_W-1:0] best_r_r;
  logic                         out_valid_r;
  logic [gmlr_pkg::R_OUT_W-1:0] out_r_r;
  logic [OW-1:0]                out_idx_r;

  logic                         take;
  logic                         finish;
  logic [IDX_W-1:0]             win_idx;
  logic [IDX_W+OW-1:0]          win_ext;

  // Strict compare keeps the lowest index on equal cost.
  assign take    = pt_ctl.valid && (pt_ctl.first || (pt_cost < best_cost_r));
  assign finish  = pt_ctl.valid && pt_ctl.last;
  assign stall   = finish && out_valid_r && !out_ready;
  assign win_idx = take ? pt_idx : best_idx_r;
  assign win_ext = {{OW{1'b0}}, win_idx};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish && !stall) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !stall) begin
      best_cost_r <= pt_cost;
      best_idx_r  <= pt_idx;
      best_r_r    <= pt_r;
    end
    if (finish && !stall) begin
      out_r_r   <= take ? pt_r : best_r_r;
      out_idx_r <= win_ext[OW-1:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_log_ratio  = out_r_r;
  assign out_best_index = out_idx_r;

  a_stall_holds_best: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> $stable(best_cost_r) && $stable(best_idx_r))
    else $error("running minimum changed during a stall");

  a_finish_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    finish && !stall |=> out_valid_r)
    else $error("last grid point did not produce a result");

  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    stall |-> out_valid_r && !out_ready)
    else $error("pipeline held while the result register could take a result");

endmodule

`default_nettype wire

@@ sv/grid_map_log_ratio_estimator.sv @@
// Top level of the grid MAP log-ratio estimator: configuration registers, point sequencer,
// cost pipeline and minimum selection. Depends on gmlr_pkg and all gmlr_* modules.
//
// Use: a request on the in_ channel carries an observation pair (obs_u, obs_v), both
// signed Q16.16. The block scans every one of GRID_POINTS log-ratio grid points, one
// point per cycle, through a nine-stage cost pipeline, and keeps the point of least cost.
// One result leaves on the out_ channel per request: the winning r in Q3.12 and its
// index (low eight bits); on equal cost the lower index wins.
// The sequencer issues one grid point a cycle while the pipeline is not held, and a
// new request is taken in the cycle its predecessor's last point issues, so consecutive
// scans run back to back through the pipeline.
// Configuration is written through cfg_wr_en/cfg_index/cfg_data; the user must write it
// only while no request is in flight, as the block itself does not enforce this. An
// index outside the register list is ignored.
// Reset (synchronous, rst_n low) empties the pipeline and the result register and loads
// the registers with 0.5, 0.5 and 0. The grid tables are constant and need no setup.
// When the receiver stalls, a finished result waits in the output register; the next
// scan runs on, and the whole pipeline holds only when its last point arrives while the
// output register is still full.
`default_nettype none

module grid_map_log_ratio_estimator #(
  parameter int GRID_POINTS = gmlr_pkg::GRID_POINTS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [31:0]                   in_obs_u,
  input  wire logic signed [31:0]                   in_obs_v,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [gmlr_pkg::R_OUT_W-1:0]       out_log_ratio,
  output logic [gmlr_pkg::IDX_OUT_W-1:0]            out_best_index,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [gmlr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [gmlr_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int IDX_W = $clog2(GRID_POINTS);

  // Configuration registers
  logic [31:0]        prior_var_r;
  logic [31:0]        noise_var_r;
  logic signed [15:0] prior_mean_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prior_var_r  <= gmlr_pkg::PRIOR_VAR_RST;
      noise_var_r  <= gmlr_pkg::NOISE_VAR_RST;
      prior_mean_r <= gmlr_pkg::PRIOR_MEAN_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        gmlr_pkg::CFG_PRIOR_VAR:  prior_var_r  <= cfg_data;
        gmlr_pkg::CFG_NOISE_VAR:  noise_var_r  <= cfg_data;
        gmlr_pkg::CFG_PRIOR_MEAN: prior_mean_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Point sequencer: holds the current observation pair and steps the grid index.
  logic               busy_r;
  logic [IDX_W-1:0]   idx_r;
  logic signed [31:0] u_r;
  logic signed [31:0] v_r;
  logic               seq_last;
  logic               stall;
  logic               adv;
  logic               accept;
  gmlr_pkg::ctl_t     seq_ctl;

  assign adv      = !stall;
  assign seq_last = (idx_r == IDX_W'(GRID_POINTS - 1));
  assign in_ready = !busy_r || (seq_last && adv);
  assign accept   = in_valid && in_ready;

  assign seq_ctl.valid = busy_r;
  assign seq_ctl.first = (idx_r == '0);
  assign seq_ctl.last  = seq_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (accept) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (busy_r && adv) begin
      if (seq_last) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      u_r <= in_obs_u;
      v_r <= in_obs_v;
    end
  end

  // Cost pipeline and minimum selection
  gmlr_pkg::ctl_t               pt_ctl;
  logic [IDX_W-1:0]             pt_idx;
  logic [gmlr_pkg::R_OUT_W-1:0] pt_r;
  logic [gmlr_pkg::COST_W-1:0]  pt_cost;
  logic [gmlr_pkg::R_OUT_W-1:0] res_r;

  gmlr_cost_pipe #(
    .GRID_POINTS(GRID_POINTS),
    .IDX_W      (IDX_W)
  ) u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_ctl    (seq_ctl),
    .in_idx    (idx_r),
    .in_u      (u_r),
    .in_v      (v_r),
    .prior_var (prior_var_r),
    .noise_var (noise_var_r),
    .prior_mean(prior_mean_r),
    .out_ctl   (pt_ctl),
    .out_idx   (pt_idx),
    .out_r     (pt_r),
    .out_cost  (pt_cost)
  );

  gmlr_min_select #(
    .GRID_POINTS(GRID_POINTS),
    .IDX_W      (IDX_W)
  ) u_min (
    .clk           (clk),
    .rst_n         (rst_n),
    .pt_ctl        (pt_ctl),
    .pt_idx        (pt_idx),
    .pt_r          (pt_r),
    .pt_cost       (pt_cost),
    .out_ready     (out_ready),
    .stall         (stall),
    .out_valid     (out_valid),
    .out_log_ratio (res_r),
    .out_best_index(out_best_index)
  );

  assign out_log_ratio = $signed(res_r);

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy_r && (idx_r == '0))
    else $error("accepted request did not start a scan at grid point zero");

  a_no_accept_mid_scan: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !seq_last |-> !in_ready)
    else $error("request taken while a scan is still issuing points");

  a_idle_is_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> in_ready)
    else $error("idle sequencer refused a request");

endmodule

`default_nettype wire
